@@ hdl/byte_stack_machine_macros.svh @@
// Assertion macros for the byte stack machine.
// Used by bsm_alu and byte_stack_machine; expects clk and arst_n in scope.
`ifndef BYTE_STACK_MACHINE_MACROS_SVH
`define BYTE_STACK_MACHINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/bsm_pkg.sv @@
// Shared constants, types and the microcode table of the byte stack machine.
// No dependencies; imported by bsm_alu and byte_stack_machine.
`default_nettype none

package bsm_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int DEP_W       = $clog2(STACK_DEPTH + 1);

	localparam logic [3:0] OP_HLT = 4'd0;
	localparam logic [3:0] OP_PSH = 4'd1;
	localparam logic [3:0] OP_POP = 4'd2;
	localparam logic [3:0] OP_PRT = 4'd3;
	localparam logic [3:0] OP_ADD = 4'd4;
	localparam logic [3:0] OP_SUB = 4'd5;
	localparam logic [3:0] OP_MUL = 4'd6;
	localparam logic [3:0] OP_DIV = 4'd7;
	localparam logic [3:0] OP_MOD = 4'd8;
	localparam logic [3:0] OP_NOP = 4'd9;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_UNKNOWN = 3'd1;
	localparam logic [2:0] ST_UNDER   = 3'd2;
	localparam logic [2:0] ST_OVER    = 3'd3;
	localparam logic [2:0] ST_DIVZERO = 3'd4;

	typedef logic [3:0] upc_t;

	// Microcode addresses
	localparam upc_t U_IDLE  = 4'd0;
	localparam upc_t U_DISP  = 4'd1;
	localparam upc_t U_HLT   = 4'd2;
	localparam upc_t U_PSH   = 4'd3;
	localparam upc_t U_POP   = 4'd4;
	localparam upc_t U_PRT0  = 4'd5;
	localparam upc_t U_PRT1  = 4'd6;
	localparam upc_t U_BIN0  = 4'd7;
	localparam upc_t U_BIN1  = 4'd8;
	localparam upc_t U_BIN2  = 4'd9;
	localparam upc_t U_BIN3  = 4'd10;
	localparam upc_t U_BIN4  = 4'd11;
	localparam upc_t U_BIN5  = 4'd12;
	localparam upc_t U_DZ    = 4'd13;
	localparam upc_t U_FIN   = 4'd14;
	localparam upc_t U_FWAIT = 4'd15;

	// Jump conditions: taken -> target, otherwise fall through
	localparam logic [2:0] C_NEVER   = 3'd0;
	localparam logic [2:0] C_ALWAYS  = 3'd1;
	localparam logic [2:0] C_NOREQ   = 3'd2;
	localparam logic [2:0] C_DISP    = 3'd3;
	localparam logic [2:0] C_DIVZ    = 3'd4;
	localparam logic [2:0] C_ALUBUSY = 3'd5;
	localparam logic [2:0] C_OUTFREE = 3'd6;

	localparam logic [1:0] RD_NONE = 2'd0;
	localparam logic [1:0] RD_TOP  = 2'd1;
	localparam logic [1:0] RD_SEC  = 2'd2;

	localparam logic [1:0] WR_NONE = 2'd0;
	localparam logic [1:0] WR_PUSH = 2'd1;
	localparam logic [1:0] WR_RES  = 2'd2;

	typedef struct packed {
		logic [2:0] cond;
		upc_t       target;
		logic [1:0] rd_sel;
		logic [1:0] wr_sel;
		logic       ld_a;
		logic       ld_b;
		logic       dep_inc;
		logic       dep_dec;
		logic       halt;
		logic       prt;
		logic       st_ld;
		logic       st_dz;
		logic       alu_go;
		logic       done;
	} uword_t;

	typedef struct packed {
		logic       go;
		logic [3:0] op;
	} alu_req_t;

	function automatic uword_t ucode(input upc_t pc);
		uword_t w;
		w = '0;
		unique case (pc)
			U_IDLE: begin
				w.cond   = C_NOREQ;
				w.target = U_IDLE;
			end
			U_DISP: begin
				w.cond  = C_DISP;
				w.st_ld = 1'b1;
			end
			U_HLT: begin
				w.halt   = 1'b1;
				w.cond   = C_ALWAYS;
				w.target = U_FIN;
			end
			U_PSH: begin
				w.wr_sel  = WR_PUSH;
				w.dep_inc = 1'b1;
				w.cond    = C_ALWAYS;
				w.target  = U_FIN;
			end
			U_POP: begin
				w.dep_dec = 1'b1;
				w.cond    = C_ALWAYS;
				w.target  = U_FIN;
			end
			U_PRT0: begin
				w.rd_sel = RD_TOP;
			end
			U_PRT1: begin
				w.prt    = 1'b1;
				w.cond   = C_ALWAYS;
				w.target = U_FIN;
			end
			U_BIN0: begin
				w.rd_sel = RD_TOP;
			end
			U_BIN1: begin
				w.ld_a   = 1'b1;
				w.rd_sel = RD_SEC;
			end
			U_BIN2: begin
				w.ld_b   = 1'b1;
				w.cond   = C_DIVZ;
				w.target = U_DZ;
			end
			U_BIN3: begin
				w.alu_go = 1'b1;
			end
			U_BIN4: begin
				w.cond   = C_ALUBUSY;
				w.target = U_BIN4;
			end
			U_BIN5: begin
				w.wr_sel  = WR_RES;
				w.dep_dec = 1'b1;
				w.cond    = C_ALWAYS;
				w.target  = U_FIN;
			end
			U_DZ: begin
				w.st_dz  = 1'b1;
				w.cond   = C_ALWAYS;
				w.target = U_FIN;
			end
			U_FIN: begin
				w.done   = 1'b1;
				w.cond   = C_OUTFREE;
				w.target = U_IDLE;
			end
			U_FWAIT: begin
				w.cond   = C_ALWAYS;
				w.target = U_FIN;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = U_IDLE;
			end
		endcase
		return w;
	endfunction

	// Map an opcode to the first step of its routine; skipped items go to U_FIN.
	function automatic upc_t op_entry(input logic [3:0] op, input logic skip);
		upc_t t;
		t = U_FIN;
		if (!skip) begin
			case (op) inside
				OP_HLT:                                 t = U_HLT;
				OP_PSH:                                 t = U_PSH;
				OP_POP:                                 t = U_POP;
				OP_PRT:                                 t = U_PRT0;
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: t = U_BIN0;
				default:                                t = U_FIN;
			endcase
		end
		return t;
	endfunction

endpackage

`default_nettype wire

@@ hdl/bsm_instr_if.sv @@
// Instruction channel of the byte stack machine: valid/ready plus opcode and immediate.
// No dependencies.
`default_nettype none

interface bsm_instr_if;
	logic       valid;
	logic       ready;
	logic [3:0] action;
	logic [7:0] immediate;

	modport source (output valid, action, immediate, input ready);
	modport sink   (input valid, action, immediate, output ready);
endinterface

`default_nettype wire

@@ hdl/bsm_result_if.sv @@
// Result channel of the byte stack machine: valid/ready plus one result per instruction.
// No dependencies.
`default_nettype none

interface bsm_result_if;
	logic       valid;
	logic       ready;
	logic       print_valid;
	logic [7:0] print_value;
	logic [2:0] status;
	logic       halted;
	logic [6:0] stack_depth;

	modport source (output valid, print_valid, print_value, status, halted, stack_depth,
		input ready);
	modport sink   (input valid, print_valid, print_value, status, halted, stack_depth,
		output ready);
endinterface

`default_nettype wire

@@ hdl/bsm_alu.sv @@
// Byte ALU: registered add/sub/mul, restoring divider one quotient bit per cycle.
// Depends on bsm_pkg and byte_stack_machine_macros.svh.
`default_nettype none
`include "byte_stack_machine_macros.svh"

module bsm_alu import bsm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire alu_req_t req,
	input  wire logic [7:0] a,
	input  wire logic [7:0] b,
	output logic          busy,
	output logic [7:0]    result
);

	localparam int DIV_STEPS = 8;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [3:0]       op_q;
	logic [7:0]       res_q;
	logic [7:0]       rem_q;
	logic [7:0]       quo_q;
	logic [7:0]       dvs_q;
	logic [15:0]      prod;
	logic [8:0]       shifted;
	logic [9:0]       diff;
	logic             is_div;

	assign is_div  = (req.op == OP_DIV) || (req.op == OP_MOD);
	assign prod    = b * a;
	assign shifted = {rem_q, quo_q[7]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.go && is_div) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			op_q  <= req.op;
			dvs_q <= a;
			rem_q <= 8'd0;
			quo_q <= b;
			case (req.op)
				OP_ADD:  res_q <= b + a;
				OP_SUB:  res_q <= b - a;
				default: res_q <= prod[7:0];
			endcase
		end else if (busy_q) begin
			// keep the trial difference when it does not borrow
			rem_q <= diff[9] ? shifted[7:0] : diff[7:0];
			quo_q <= {quo_q[6:0], ~diff[9]};
		end
	end

	always_comb begin
		case (op_q)
			OP_DIV:  result = quo_q;
			OP_MOD:  result = rem_q;
			default: result = res_q;
		endcase
	end

	assign busy = busy_q;

	`BSM_ASSERT_NOW(a_no_start_busy, req.go, !busy_q, "ALU started while divider busy")
	`BSM_ASSERT_NEXT(a_div_ends, busy_q && (cnt_q == CNT_W'(1)), !busy_q, "divider overran")
	`BSM_ASSERT_NEXT(a_div_starts, req.go && is_div, busy_q, "divide did not start")

endmodule

`default_nettype wire

@@ hdl/byte_stack_machine.sv @@
// Byte stack machine: one instruction in, one result out, under a microcoded sequencer.
// Each instruction runs from U_IDLE through U_DISP and its routine to U_FIN: NOP and skipped
// items go straight to U_FIN, divide by zero ends in U_DZ, and DIV/MOD wait in U_BIN4 for the
// divider (8 divider steps). The next instruction is taken only once the sequencer is back in
// U_IDLE, and a result left waiting in the output register holds the sequencer, retrying via U_FWAIT.
// Reset clears depth, halt flag, sequencer and output valid; the stack RAM is not cleared.
`default_nettype none
`include "byte_stack_machine_macros.svh"

module byte_stack_machine import bsm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	bsm_instr_if.sink    instr,
	bsm_result_if.source result
);

	logic [7:0]       mem [STACK_DEPTH];
	logic [7:0]       rdata_q;
	upc_t             upc_q;
	upc_t             upc_d;
	uword_t           uw;
	logic [DEP_W-1:0] depth_q;
	logic             halt_q;
	logic [3:0]       op_q;
	logic [7:0]       imm_q;
	logic [7:0]       a_q;
	logic [7:0]       b_q;
	logic [2:0]       status_q;
	logic             pvalid_q;
	logic [7:0]       pvalue_q;
	logic             out_valid_q;
	logic             out_pvalid_q;
	logic [7:0]       out_pvalue_q;
	logic [2:0]       out_status_q;
	logic             out_halted_q;
	logic [6:0]       out_depth_q;
	logic             accept;
	logic             out_free;
	logic             emit;
	logic             take;
	logic             divz;
	logic [2:0]       chk_status;
	logic             mem_we;
	logic             mem_re;
	logic [SP_W-1:0]  wr_addr;
	logic [SP_W-1:0]  rd_addr;
	logic [7:0]       wr_data;
	alu_req_t         alu_req;
	logic             alu_busy;
	logic [7:0]       alu_res;

	assign uw           = ucode(upc_q);
	assign instr.ready  = (upc_q == U_IDLE);
	assign accept       = instr.valid && instr.ready;
	assign out_free     = !out_valid_q || result.ready;
	assign emit         = uw.done && out_free;
	assign divz         = ((op_q == OP_DIV) || (op_q == OP_MOD)) && (a_q == 8'd0);

	// Fault check of the held instruction against the current depth
	always_comb begin
		chk_status = ST_OK;
		case (op_q) inside
			OP_HLT, OP_NOP: chk_status = ST_OK;
			OP_PSH: begin
				if (depth_q >= DEP_W'(STACK_DEPTH)) chk_status = ST_OVER;
			end
			OP_POP, OP_PRT: begin
				if (depth_q == '0) chk_status = ST_UNDER;
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
				if (depth_q < DEP_W'(2)) chk_status = ST_UNDER;
			end
			default: chk_status = ST_UNKNOWN;
		endcase
	end

	// Sequencer: taken jump goes to target, otherwise advance
	always_comb begin
		unique case (uw.cond)
			C_NEVER:   take = 1'b0;
			C_ALWAYS:  take = 1'b1;
			C_NOREQ:   take = !accept;
			C_DISP:    take = 1'b1;
			C_DIVZ:    take = divz;
			C_ALUBUSY: take = alu_busy;
			C_OUTFREE: take = out_free;
			default:   take = 1'b1;
		endcase
		if (!take) begin
			upc_d = upc_q + upc_t'(1);
		end else if (uw.cond == C_DISP) begin
			upc_d = op_entry(op_q, halt_q || (chk_status != ST_OK));
		end else begin
			upc_d = uw.target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q   <= U_IDLE;
			depth_q <= '0;
			halt_q  <= 1'b0;
		end else begin
			upc_q <= upc_d;
			if (uw.dep_inc) begin
				depth_q <= depth_q + DEP_W'(1);
			end else if (uw.dep_dec) begin
				depth_q <= depth_q - DEP_W'(1);
			end
			if (uw.halt) begin
				halt_q <= 1'b1;
			end
		end
	end

	// Working registers of the current instruction
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= instr.action;
			imm_q <= instr.immediate;
		end
		if (uw.ld_a) a_q <= rdata_q;
		if (uw.ld_b) b_q <= rdata_q;
		if (uw.st_ld) begin
			status_q <= halt_q ? ST_OK : chk_status;
			pvalid_q <= 1'b0;
			pvalue_q <= 8'd0;
		end else if (uw.st_dz) begin
			status_q <= ST_DIVZERO;
		end else if (uw.prt) begin
			pvalid_q <= 1'b1;
			pvalue_q <= rdata_q;
		end
	end

	// Stack RAM: one write port, one registered read port
	assign mem_we  = (uw.wr_sel != WR_NONE);
	assign mem_re  = (uw.rd_sel != RD_NONE);
	assign wr_addr = (uw.wr_sel == WR_PUSH) ? SP_W'(depth_q) : SP_W'(depth_q - DEP_W'(2));
	assign wr_data = (uw.wr_sel == WR_PUSH) ? imm_q : alu_res;
	assign rd_addr = (uw.rd_sel == RD_TOP) ? SP_W'(depth_q - DEP_W'(1))
		: SP_W'(depth_q - DEP_W'(2));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign alu_req.go = uw.alu_go;
	assign alu_req.op = op_q;

	bsm_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (a_q),
		.b      (b_q),
		.busy   (alu_busy),
		.result (alu_res)
	);

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pvalid_q <= pvalid_q;
			out_pvalue_q <= pvalue_q;
			out_status_q <= status_q;
			out_halted_q <= halt_q;
			out_depth_q  <= 7'(depth_q);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.print_valid = out_pvalid_q;
	assign result.print_value = out_pvalue_q;
	assign result.status      = out_status_q;
	assign result.halted      = out_halted_q;
	assign result.stack_depth = out_depth_q;

	`BSM_ASSERT_NOW(a_depth_range, 1'b1, depth_q <= DEP_W'(STACK_DEPTH), "stack depth out of range")
	`BSM_ASSERT_NOW(a_no_write_halted, mem_we, !halt_q, "stack written while halted")
	`BSM_ASSERT_NEXT(a_accept_disp, accept, upc_q == U_DISP, "accept not followed by dispatch")

endmodule

`default_nettype wire

@@ verif/byte_stack_machine_test.sv @@
// Self-checking testbench for byte_stack_machine: random and directed instruction streams.
// Depends on bsm_pkg, bsm_instr_if, bsm_result_if and the byte_stack_machine RTL.
`timescale 1ns / 1ps

module byte_stack_machine_test;
	import bsm_pkg::*;

	localparam logic [3:0] OP_FIRST_UNKNOWN = OP_NOP + 4'd1;
	localparam logic [3:0] OP_LAST_CODE     = 4'hF;
	localparam int IDLE_PCT      = 34;
	localparam int RANDOM_ITEMS  = 1600;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic [3:0] action;
		logic [7:0] immediate;
	} instr_t;

	typedef struct packed {
		logic       print_valid;
		logic [7:0] print_value;
		logic [2:0] status;
		logic       halted;
		logic [6:0] stack_depth;
	} machine_result_t;

	typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bsm_instr_if  instr_ch();
	bsm_result_if result_ch();

	byte_stack_machine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch)
	);

	always #2 clk = ~clk;

	// Predictor state
	logic [7:0]  stack_image [STACK_DEPTH];
	int unsigned depth_now = 0;
	bit          halt_seen = 1'b0;

	instr_t          instr_backlog[$];
	machine_result_t expected_results[$];
	instr_t          staged;
	machine_result_t want;
	int              results_seen = 0;
	int              hold_left = 0;
	bit              hold_done = 1'b0;
	bit              failed = 1'b0;
	logic            calm;

	// Both sides stop idling inside this window
	assign calm = (results_seen >= 700) && (results_seen < 1000);

	function automatic machine_result_t execute_instr(input logic [3:0] op, input logic [7:0] imm);
		machine_result_t r;
		logic [7:0] a, b, folded;
		r = '0;
		if (!halt_seen) begin
			case (op)
				OP_HLT: halt_seen = 1'b1;
				OP_PSH: begin
					if (depth_now >= STACK_DEPTH)
						r.status = ST_OVER;
					else begin
						stack_image[depth_now] = imm;
						depth_now++;
					end
				end
				OP_POP: begin
					if (depth_now == 0)
						r.status = ST_UNDER;
					else
						depth_now--;
				end
				OP_PRT: begin
					if (depth_now == 0)
						r.status = ST_UNDER;
					else begin
						r.print_valid = 1'b1;
						r.print_value = stack_image[depth_now - 1];
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
					if (depth_now < 2)
						r.status = ST_UNDER;
					else begin
						a = stack_image[depth_now - 1];
						b = stack_image[depth_now - 2];
						if ((op == OP_DIV || op == OP_MOD) && a == 8'd0)
							r.status = ST_DIVZERO;
						else begin
							case (op)
								OP_ADD:  folded = b + a;
								OP_SUB:  folded = b - a;
								OP_MUL:  folded = b * a;
								OP_DIV:  folded = b / a;
								default: folded = b % a;
							endcase
							stack_image[depth_now - 2] = folded;
							depth_now--;
						end
					end
				end
				OP_NOP: ;
				default: r.status = ST_UNKNOWN;
			endcase
		end
		r.halted      = halt_seen;
		r.stack_depth = 7'(depth_now);
		return r;
	endfunction

	function automatic logic [3:0] pick_action(input phase_kind_t kind);
		int unsigned r;
		logic [3:0] binop;
		r = $urandom_range(0, 99);
		binop = 4'($urandom_range(OP_ADD, OP_MOD));
		case (kind)
			PH_FILL:  return (r < 75) ? OP_PSH : (r < 85) ? OP_PRT : (r < 95) ? binop : OP_POP;
			PH_DRAIN: return (r < 15) ? OP_PSH : (r < 30) ? OP_POP : (r < 40) ? OP_PRT :
				(r < 90) ? binop : OP_NOP;
			PH_MIXED: return (r < 40) ? OP_PSH : (r < 48) ? OP_POP : (r < 60) ? OP_PRT :
				(r < 90) ? binop : (r < 95) ? OP_NOP :
				4'($urandom_range(OP_FIRST_UNKNOWN, OP_LAST_CODE));
			default:  return 4'($urandom_range(OP_PSH, OP_LAST_CODE));
		endcase
	endfunction

	// Bias pushed bytes toward zero, small divisors and the top value
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'($urandom_range(1, 8));
			2:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic add_instr(input logic [3:0] op, input logic [7:0] imm);
		instr_backlog.push_back('{action: op, immediate: imm});
	endtask

	task automatic wait_drained();
		while (instr_backlog.size() != 0 || instr_ch.valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Request driver: predict on acceptance, then offer the next request or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			instr_ch.valid     <= 1'b0;
			instr_ch.action    <= OP_NOP;
			instr_ch.immediate <= 8'd0;
		end else begin
			if (instr_ch.valid && instr_ch.ready)
				expected_results.push_back(execute_instr(instr_ch.action, instr_ch.immediate));
			if (!instr_ch.valid || instr_ch.ready) begin
				if (instr_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					staged = instr_backlog.pop_front();
					instr_ch.valid     <= 1'b1;
					instr_ch.action    <= staged.action;
					instr_ch.immediate <= staged.immediate;
				end else begin
					instr_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result ready: random stalls plus one long hold while requests keep coming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left       <= 0;
			hold_done       <= 1'b0;
		end else if (hold_left != 0) begin
			result_ch.ready <= 1'b0;
			hold_left       <= hold_left - 1;
		end else if (!hold_done && results_seen >= 300 && instr_backlog.size() > 20) begin
			result_ch.ready <= 1'b0;
			hold_left       <= HOLD_CYCLES;
			hold_done       <= 1'b1;
		end else begin
			result_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding: status %0d depth %0d",
					result_ch.status, result_ch.stack_depth);
				failed = 1'b1;
			end else begin
				want = expected_results.pop_front();
				if (result_ch.print_valid !== want.print_valid) begin
					$error("print_valid: expected %0d, got %0d", want.print_valid,
						result_ch.print_valid);
					failed = 1'b1;
				end
				if (result_ch.print_value !== want.print_value) begin
					$error("print_value: expected %0d, got %0d", want.print_value,
						result_ch.print_value);
					failed = 1'b1;
				end
				if (result_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result_ch.status);
					failed = 1'b1;
				end
				if (result_ch.halted !== want.halted) begin
					$error("halted: expected %0d, got %0d", want.halted, result_ch.halted);
					failed = 1'b1;
				end
				if (result_ch.stack_depth !== want.stack_depth) begin
					$error("stack_depth: expected %0d, got %0d", want.stack_depth,
						result_ch.stack_depth);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("byte_stack_machine_test failed");
		$finish;
	end

	initial begin
		int issued;
		int span;
		phase_kind_t kind;
		instr_t item;

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Empty-stack underflows, wraparound, divide by zero, unknown codes
		add_instr(OP_POP, 8'h00);
		add_instr(OP_PRT, 8'hFF);
		add_instr(OP_ADD, 8'h00);
		add_instr(OP_PSH, 8'hFF);
		add_instr(OP_SUB, 8'hAA);
		add_instr(OP_PRT, 8'h55);
		add_instr(OP_PSH, 8'h00);
		add_instr(OP_DIV, 8'h00);
		add_instr(OP_MOD, 8'hFF);
		add_instr(OP_ADD, 8'h00);
		add_instr(OP_PSH, 8'h01);
		add_instr(OP_ADD, 8'h00);
		add_instr(OP_PSH, 8'h01);
		add_instr(OP_SUB, 8'h00);
		add_instr(OP_PSH, 8'hFF);
		add_instr(OP_MUL, 8'h00);
		add_instr(OP_PSH, 8'hFE);
		add_instr(OP_PSH, 8'h07);
		add_instr(OP_DIV, 8'h00);
		add_instr(OP_PSH, 8'h05);
		add_instr(OP_MOD, 8'h00);
		add_instr(OP_NOP, 8'hFF);
		add_instr(OP_FIRST_UNKNOWN, 8'h00);
		add_instr(OP_LAST_CODE, 8'hFF);
		add_instr(OP_PRT, 8'h00);
		wait_drained();

		// Push past the top to force an overflow
		issued = 0;
		repeat (STACK_DEPTH + 3) begin
			add_instr(OP_PSH, pick_byte());
			issued++;
		end
		add_instr(OP_PRT, 8'h00);

		while (issued < RANDOM_ITEMS) begin
			kind = phase_kind_t'($urandom_range(PH_FILL, PH_NOISE));
			span = $urandom_range(20, 120);
			repeat (span) begin
				item.action = pick_action(kind);
				item.immediate = (item.action == OP_PSH) ? pick_byte() :
					8'($urandom_range(0, 255));
				add_instr(item.action, item.immediate);
				issued++;
			end
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end

		// Halt, then check that later requests are ignored
		add_instr(OP_HLT, 8'($urandom_range(0, 255)));
		repeat (8)
			add_instr(4'($urandom_range(OP_HLT, OP_LAST_CODE)), 8'($urandom_range(0, 255)));
		wait_drained();
		repeat (40) @(posedge clk);

		if (!failed)
			$display("byte_stack_machine_test passed");
		else
			$display("byte_stack_machine_test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/bsm_pkg.sv
hdl/bsm_instr_if.sv
hdl/bsm_result_if.sv
hdl/bsm_alu.sv
hdl/byte_stack_machine.sv
verif/byte_stack_machine_test.sv
